>>> src/lks_pkg.sv
`default_nettype none

package lks_pkg;

   // fixed field widths
   localparam int OPCODE_W = 2;
   localparam int CAP_W    = 5;

   // defaults handed to the top-level parameters
   localparam int DEF_ENTRIES    = 16;
   localparam int DEF_KEY_BITS   = 64;
   localparam int DEF_VALUE_BITS = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // register map
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef logic [OPCODE_W-1:0] opcode_type;

   localparam opcode_type OP_INSERT = 2'd0;
   localparam opcode_type OP_READ   = 2'd1;
   localparam opcode_type OP_DELETE = 2'd2;

   // per-cell move for the cycle: hold, take from the more recent neighbour,
   // or take from the less recent neighbour
   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_FROM_PREV = 2'd1,
      CELL_FROM_NEXT = 2'd2
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_LOOK  = 3'b010,
      ST_APPLY = 3'b100
   } ctrl_state_type;

endpackage

`default_nettype wire

>>> src/lks_cell.sv
`default_nettype none

module lks_cell
   import lks_pkg::*;
#(
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire cell_op_type           op,
   input  wire logic [KEY_BITS-1:0]   look_key,
   input  wire logic [KEY_BITS-1:0]   prev_key,
   input  wire logic [VALUE_BITS-1:0] prev_value,
   input  wire logic [KEY_BITS-1:0]   next_key,
   input  wire logic [VALUE_BITS-1:0] next_value,
   output logic      [KEY_BITS-1:0]   key_out,
   output logic      [VALUE_BITS-1:0] value_out,
   output logic                       match
);

   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   always_ff @(posedge clock) begin
      case (op)
         CELL_FROM_PREV: begin
            key_ff   <= prev_key;
            value_ff <= prev_value;
         end
         CELL_FROM_NEXT: begin
            key_ff   <= next_key;
            value_ff <= next_value;
         end
         default: begin
            key_ff   <= key_ff;
            value_ff <= value_ff;
         end
      endcase
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;
   assign match     = (key_ff == look_key);

endmodule

`default_nettype wire

>>> src/lks_ctrl.sv
`default_nettype none

module lks_ctrl
   import lks_pkg::*;
#(
   parameter int ENTRIES    = DEF_ENTRIES,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [CAP_W-1:0]      capacity,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire opcode_type            req_opcode,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic                       rsp_ok,
   output logic      [VALUE_BITS-1:0] rsp_value,
   output logic                       rsp_evicted,
   input  wire logic [ENTRIES-1:0]    cell_match,
   input  wire logic [VALUE_BITS-1:0] cell_value [ENTRIES],
   output cell_op_type                cell_op [ENTRIES],
   output logic      [KEY_BITS-1:0]   look_key,
   output logic      [VALUE_BITS-1:0] load_value
);

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int POS_W = $clog2(ENTRIES);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   ctrl_state_type state_ff, state_in;

   logic [CNT_W-1:0]      count_ff, count_in;
   opcode_type            op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic                  evict_ff;
   logic                  hit_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [VALUE_BITS-1:0] hit_val_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_ok_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_evicted_ff;

   logic                  req_fire;
   logic                  apply_fire;
   logic [CMP_W-1:0]      cap_eff;
   logic [ENTRIES-1:0]    qual_match;
   logic [POS_W-1:0]      match_pos;
   logic [VALUE_BITS-1:0] match_val;
   logic                  ok_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign apply_fire = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_tready);

   // saturate capacity into 1..ENTRIES
   always_comb begin
      cap_eff = CMP_W'(capacity);
      if (capacity == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
   end

   // live cells sit at positions below the count; mask the victim of an eviction
   always_comb begin
      match_pos = '0;
      match_val = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         qual_match[i] = cell_match[i] && (CNT_W'(i) < count_ff) &&
                         !(evict_ff && (CNT_W'(i + 1) == count_ff));
         match_pos = match_pos | (qual_match[i] ? POS_W'(i) : POS_W'(0));
         match_val = match_val | ({VALUE_BITS{qual_match[i]}} & cell_value[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         cell_op[i] = CELL_HOLD;
         if (apply_fire) begin
            case (op_ff)
               OP_INSERT: begin
                  if (!hit_ff) begin
                     cell_op[i] = CELL_FROM_PREV;
                  end
               end
               OP_READ: begin
                  if (hit_ff && (POS_W'(i) <= pos_ff)) begin
                     cell_op[i] = CELL_FROM_PREV;
                  end
               end
               OP_DELETE: begin
                  if (hit_ff && (POS_W'(i) >= pos_ff)) begin
                     cell_op[i] = CELL_FROM_NEXT;
                  end
               end
               default: cell_op[i] = CELL_HOLD;
            endcase
         end
      end
   end

   assign look_key   = key_ff;
   assign load_value = (op_ff == OP_READ) ? hit_val_ff : val_ff;

   always_comb begin
      case (op_ff)
         OP_INSERT: ok_next = !hit_ff;
         OP_READ:   ok_next = hit_ff;
         OP_DELETE: ok_next = hit_ff;
         default:   ok_next = 1'b0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (apply_fire) begin
         case (op_ff)
            OP_INSERT: count_in = count_ff + CNT_W'(!hit_ff) - CNT_W'(evict_ff);
            OP_DELETE: count_in = count_ff - CNT_W'(hit_ff);
            default:   count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_APPLY;
         ST_APPLY: if (apply_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (apply_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_opcode;
         key_ff   <= req_key;
         val_ff   <= req_value;
         evict_ff <= (req_opcode == OP_INSERT) && (CMP_W'(count_ff) >= cap_eff);
      end
      if (state_ff == ST_LOOK) begin
         hit_ff     <= |qual_match;
         pos_ff     <= match_pos;
         hit_val_ff <= match_val;
      end
      if (apply_fire) begin
         rsp_ok_ff      <= ok_next;
         rsp_value_ff   <= ((op_ff == OP_READ) && hit_ff) ? hit_val_ff : '0;
         rsp_evicted_ff <= (op_ff == OP_INSERT) && evict_ff;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_evicted = rsp_evicted_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(ENTRIES))
      else $error("entry count beyond the number of cells");

   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |-> $onehot0(qual_match))
      else $error("key present in more than one live cell");

   a_evict_nonempty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_LOOK) && evict_ff) |-> (count_ff != '0))
      else $error("eviction requested on an empty store");

   a_apply_result: assert property (@(posedge clock) disable iff (reset)
      apply_fire |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("update did not post a result");

endmodule

`default_nettype wire

>>> src/lru_keyed_store.sv
// Path: an accepted request passes capture, key compare in every cell and shift of the
//   cell chain to its result on the rsp side; the shift waits for a free output register.
// Requests: taken one at a time in the idle state, each through compare-then-shift;
//   a new request is taken while the previous result still waits in the output register.
// Reset: synchronous, active high; clears the entry count, the handshake state and sets
//   capacity to 16. Cell contents are not cleared, so no clearing pass is needed.
`default_nettype none

module lru_keyed_store
   import lks_pkg::*;
#(
   parameter int ENTRIES    = DEF_ENTRIES,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: key, value_in (from bit 0 up), zero padded to whole bytes
   input  wire logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: opcode
   input  wire logic [OPCODE_W-1:0]   req_tuser,
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: value_out, zero padded to whole bytes
   output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // tuser: ok, evicted (from bit 0 up)
   output logic      [1:0]            rsp_tuser,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int RSP_W = ((VALUE_BITS + 7) / 8) * 8;

   logic [CAP_W-1:0]      capacity_ff;
   logic                  cap_sel;

   logic                  rsp_ok;
   logic                  rsp_evicted;
   logic [VALUE_BITS-1:0] rsp_value;

   logic [ENTRIES-1:0]    cell_match;
   logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
   logic [VALUE_BITS-1:0] cell_value [ENTRIES];
   cell_op_type           cell_op    [ENTRIES];
   logic [KEY_BITS-1:0]   look_key;
   logic [VALUE_BITS-1:0] load_value;

   // capacity register at byte address 0; higher words read as zero
   assign cap_sel    = (csr_paddr[CSR_ADDR_W-1] == 1'b0);
   assign csr_pready = 1'b1;
   assign csr_prdata = cap_sel ? CSR_DATA_W'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && cap_sel) begin
         capacity_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   lks_ctrl #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_opcode  (req_tuser),
      .req_key     (req_tdata[KEY_BITS-1:0]),
      .req_value   (req_tdata[KEY_BITS +: VALUE_BITS]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_ok      (rsp_ok),
      .rsp_value   (rsp_value),
      .rsp_evicted (rsp_evicted),
      .cell_match  (cell_match),
      .cell_value  (cell_value),
      .cell_op     (cell_op),
      .look_key    (look_key),
      .load_value  (load_value)
   );

   // cell 0 is the most recent entry; the new or promoted entry enters there
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [KEY_BITS-1:0]   prev_key;
      logic [VALUE_BITS-1:0] prev_value;
      logic [KEY_BITS-1:0]   next_key;
      logic [VALUE_BITS-1:0] next_value;

      if (i == 0) begin : g_head
         assign prev_key   = look_key;
         assign prev_value = load_value;
      end else begin : g_link_prev
         assign prev_key   = cell_key[i-1];
         assign prev_value = cell_value[i-1];
      end

      // the tail takes filler on a delete; it is beyond the count by then
      if (i == ENTRIES - 1) begin : g_tail
         assign next_key   = look_key;
         assign next_value = load_value;
      end else begin : g_link_next
         assign next_key   = cell_key[i+1];
         assign next_value = cell_value[i+1];
      end

      lks_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op[i]),
         .look_key   (look_key),
         .prev_key   (prev_key),
         .prev_value (prev_value),
         .next_key   (next_key),
         .next_value (next_value),
         .key_out    (cell_key[i]),
         .value_out  (cell_value[i]),
         .match      (cell_match[i])
      );
   end

   assign rsp_tdata = RSP_W'(rsp_value);
   assign rsp_tuser = {rsp_evicted, rsp_ok};

endmodule

`default_nettype wire
